FILE: src/dra_pkg.sv
// ----------------------------------------------------------------------------
// dra_pkg: shared types, constants and helpers
// Fixed-point widths, sequencer states and phases, and the small index
// and rounding functions used by the rotation datapath.
// ----------------------------------------------------------------------------
package dra_pkg;

  localparam int FRAC  = 30;  // fraction bits of the kept matrix
  localparam int OP_W  = 34;  // multiplier operand width
  localparam int ACC_W = 2 * OP_W;
  localparam int RND_W = 40;  // width after rounding a product sum

  localparam logic signed [31:0]    ONE32 = 32'sd1 <<< FRAC;
  localparam logic signed [OP_W-1:0] ONE_OP = OP_W'(1) <<< FRAC;
  localparam logic signed [RND_W-1:0] ONE_R = RND_W'(1) <<< FRAC;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS,
    ST_SHIFT,
    ST_MAC_A,
    ST_MAC_B,
    ST_MAC_RUN,
    ST_POST,
    ST_SQRT,
    ST_DSTART,
    ST_DIV,
    ST_COMMIT,
    ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    PH_NSQ,
    PH_NDIV,
    PH_CROSS,
    PH_DOT,
    PH_S2,
    PH_UDIV,
    PH_UU,
    PH_OMC,
    PH_SKEW,
    PH_MM
  } phase_e;

  function automatic logic [1:0] nxt3(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] row_of(input logic [3:0] e);
    logic [1:0] r;
    case (e)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] col_of(input logic [3:0] e);
    logic [1:0] r;
    case (e)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] ent(input logic [1:0] row, input logic [1:0] col);
    return ({2'b0, row} << 1) + {2'b0, row} + {2'b0, col};
  endfunction

  // Axis component that enters an off-diagonal entry through the cross matrix
  function automatic logic [1:0] skew_k(input logic [3:0] e);
    logic [1:0] r;
    case (e)
      4'd1, 4'd3: r = 2'd2;
      4'd2, 4'd6: r = 2'd1;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic skew_neg(input logic [3:0] e);
    logic r;
    case (e)
      4'd1, 4'd5, 4'd6: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  // Round half away from zero, dropping FRAC fraction bits
  function automatic logic signed [RND_W-1:0] rnd(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] sh;
    logic [RND_W-1:0] m;
    mag = v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
    sh  = (mag + (ACC_W'(1) << (FRAC - 1))) >> FRAC;
    m   = sh[RND_W-1:0];
    return v[ACC_W-1] ? signed'(~m + RND_W'(1)) : signed'(m);
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [RND_W-1:0] v);
    logic signed [31:0] r;
    if (v > ONE_R) begin
      r = ONE32;
    end else if (v < -ONE_R) begin
      r = -ONE32;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: src/drag_rotation_accumulator.sv
// ----------------------------------------------------------------------------
// drag_rotation_accumulator: arcball rotation kept as a 3x3 Q2.30 matrix
// Input beat: func_i plus start and end points (Q16.16). func_i = 1 loads
// the identity; func_i = 0 rotates the kept matrix by the drag from the
// start direction to the end direction (Rodrigues' formula, left product).
// A zero vector or a parallel pair leaves the matrix unchanged.
// Every input beat yields one output beat carrying all nine entries.
// One item is in work at a time; in_ready_o is high only while idle.
// A full drag runs 69 products through a bit-serial multiplier, nine
// divisions and three square roots, after the shifts that normalize
// each input vector.
// A reset item or a zero start vector skips the arithmetic; a zero end vector
// stops after the start vector is normalized, a parallel pair at the sine root.
// Results sit in an output register; a new item is taken while an old
// result waits, and a finished item holds until out_ready_i frees it.
// After reset the kept matrix is the identity and no result is pending.
// ----------------------------------------------------------------------------
module drag_rotation_accumulator
  import dra_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  input  logic signed [31:0] end_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] r00_o,
  output logic signed [31:0] r01_o,
  output logic signed [31:0] r02_o,
  output logic signed [31:0] r10_o,
  output logic signed [31:0] r11_o,
  output logic signed [31:0] r12_o,
  output logic signed [31:0] r20_o,
  output logic signed [31:0] r21_o,
  output logic signed [31:0] r22_o
);

  state_e state_q, state_d;
  phase_e ph_q, ph_d;
  logic [3:0] idx_q, idx_d;
  logic [1:0] term_q, term_d;
  logic       vsel_q, vsel_d;
  logic       out_valid_q, out_valid_d;

  logic signed [31:0]       sv_q [3], sv_d [3], ev_q [3], ev_d [3];
  logic [31:0]              m_q [3], m_d [3];
  logic signed [31:0]       a_q [3], a_d [3], b_q [3], b_d [3];
  logic signed [OP_W-1:0]   n_q [3], n_d [3], u_q [3], u_d [3];
  logic signed [31:0]       c_q, c_d;
  logic [31:0]              sden_q, sden_d;
  logic signed [OP_W-1:0]   t_q, t_d, opa_q, opa_d;
  logic signed [RND_W-1:0]  rt_q, rt_d;
  logic signed [31:0]       r_q [9], r_d [9], nxt_q [9], nxt_d [9];
  logic signed [31:0]       rot_q [9], rot_d [9], out_q [9], out_d [9];
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  // engine hookups
  logic                    mul_start, mul_done;
  logic signed [ACC_W-1:0] mul_prod;
  logic                    sqrt_start, sqrt_done;
  logic [31:0]             sqrt_root;
  logic                    div_start, div_done;
  logic [63:0]             div_num, div_quo;

  // operand fetch
  logic signed [OP_W-1:0] opnd, omc;
  logic                   neg;
  logic [1:0]             last_term, jx, kx, rw, cl;
  logic                   pick_b;

  logic signed [31:0]      cur [3];
  logic signed [RND_W-1:0] rval, val;
  logic [OP_W-1:0]         nmag;
  logic [OP_W-1:0]         dmag;
  logic                    diag;

  dra_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (opa_q),
    .b_i    (opnd),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  dra_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .x_i    (acc_q[63:0]),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  dra_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (sden_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign pick_b = (state_q == ST_MAC_B);
  assign omc    = ONE_OP - OP_W'(c_q);
  assign jx     = nxt3(idx_q[1:0]);
  assign kx     = nxt3(jx);
  assign rw     = row_of(idx_q);
  assign cl     = col_of(idx_q);
  assign diag   = (rw == cl);

  always_comb begin
    opnd      = '0;
    neg       = 1'b0;
    last_term = 2'd0;
    case (ph_q)
      PH_NSQ: begin
        opnd      = {2'b0, m_q[term_q]};
        last_term = 2'd2;
      end
      PH_CROSS: begin
        if (pick_b) begin
          opnd = OP_W'(b_q[(term_q == 2'd0) ? kx : jx]);
        end else begin
          opnd = OP_W'(a_q[(term_q == 2'd0) ? jx : kx]);
        end
        neg       = (term_q != 2'd0);
        last_term = 2'd1;
      end
      PH_DOT: begin
        opnd      = pick_b ? OP_W'(b_q[term_q]) : OP_W'(a_q[term_q]);
        last_term = 2'd2;
      end
      PH_S2: begin
        opnd      = n_q[term_q];
        last_term = 2'd2;
      end
      PH_UU: begin
        opnd = u_q[pick_b ? cl : rw];
      end
      PH_OMC: begin
        opnd = pick_b ? t_q : omc;
      end
      PH_SKEW: begin
        opnd = pick_b ? signed'({2'b0, sden_q}) : u_q[skew_k(idx_q)];
      end
      PH_MM: begin
        opnd      = pick_b ? OP_W'(rot_q[ent(term_q, cl)]) : OP_W'(r_q[ent(rw, term_q)]);
        last_term = 2'd2;
      end
      default: begin
        opnd = '0;
      end
    endcase
  end

  // divider numerator: magnitude scaled up, plus half the divisor for rounding
  assign nmag    = n_q[idx_q[1:0]][OP_W-1] ? (~n_q[idx_q[1:0]] + OP_W'(1))
                                            : n_q[idx_q[1:0]];
  assign dmag    = (ph_q == PH_NDIV) ? {2'b0, m_q[idx_q[1:0]]} : nmag;
  assign div_num = (64'(dmag) << FRAC) + 64'(sden_q >> 1);

  assign rval = rnd(acc_q);
  assign val  = (diag ? RND_W'(c_q) : RND_W'(0)) + rval;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cur[k] = vsel_q ? ev_q[k] : sv_q[k];
    end
  end

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    idx_d       = idx_q;
    term_d      = term_q;
    vsel_d      = vsel_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    sv_d        = sv_q;
    ev_d        = ev_q;
    m_d         = m_q;
    a_d         = a_q;
    b_d         = b_q;
    n_d         = n_q;
    u_d         = u_q;
    c_d         = c_q;
    sden_d      = sden_q;
    t_d         = t_q;
    opa_d       = opa_q;
    rt_d        = rt_q;
    r_d         = r_q;
    nxt_d       = nxt_q;
    rot_d       = rot_q;
    out_d       = out_q;
    acc_d       = acc_q;
    mul_start   = 1'b0;
    sqrt_start  = 1'b0;
    div_start   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (func_i) begin
            for (int e = 0; e < 9; e++) begin
              rot_d[e] = (e == 0 || e == 4 || e == 8) ? ONE32 : 32'sd0;
            end
            state_d = ST_FINISH;
          end else begin
            sv_d[0] = start_x_i;
            sv_d[1] = start_y_i;
            sv_d[2] = start_z_i;
            ev_d[0] = end_x_i;
            ev_d[1] = end_y_i;
            ev_d[2] = end_z_i;
            vsel_d  = 1'b0;
            state_d = ST_ABS;
          end
        end
      end

      ST_ABS: begin
        for (int k = 0; k < 3; k++) begin
          m_d[k] = cur[k][31] ? (~cur[k] + 32'd1) : cur[k];
        end
        // drop the drag when either vector is zero
        if ((cur[0] | cur[1] | cur[2]) == 32'sd0) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_SHIFT;
        end
      end

      ST_SHIFT: begin
        if ((m_q[0][31:30] | m_q[1][31:30] | m_q[2][31:30]) != 2'b00) begin
          ph_d    = PH_NSQ;
          term_d  = '0;
          state_d = ST_MAC_A;
        end else begin
          for (int k = 0; k < 3; k++) begin
            m_d[k] = m_q[k] << 1;
          end
        end
      end

      ST_MAC_A: begin
        opa_d   = opnd;
        state_d = ST_MAC_B;
      end

      ST_MAC_B: begin
        mul_start = 1'b1;
        state_d   = ST_MAC_RUN;
      end

      ST_MAC_RUN: begin
        if (mul_done) begin
          acc_d = ((term_q == 2'd0) ? '0 : acc_q) + (neg ? -mul_prod : mul_prod);
          if (term_q == last_term) begin
            term_d  = '0;
            state_d = ST_POST;
          end else begin
            term_d  = term_q + 2'd1;
            state_d = ST_MAC_A;
          end
        end
      end

      ST_POST: begin
        state_d = ST_MAC_A;
        case (ph_q)
          PH_NSQ, PH_S2: begin
            sqrt_start = 1'b1;
            state_d    = ST_SQRT;
          end
          PH_CROSS: begin
            n_d[idx_q[1:0]] = OP_W'(rval);
            if (idx_q == 4'd2) begin
              idx_d = '0;
              ph_d  = PH_DOT;
            end else begin
              idx_d = idx_q + 4'd1;
            end
          end
          PH_DOT: begin
            c_d  = sat(rval);
            ph_d = PH_S2;
          end
          PH_UU: begin
            t_d  = OP_W'(rval);
            ph_d = PH_OMC;
          end
          PH_OMC, PH_SKEW: begin
            if (ph_q == PH_OMC && !diag) begin
              rt_d = val;
              ph_d = PH_SKEW;
            end else begin
              if (ph_q == PH_OMC) begin
                r_d[idx_q] = sat(val);
              end else begin
                r_d[idx_q] = sat(skew_neg(idx_q) ? rt_q - rval : rt_q + rval);
              end
              ph_d = PH_UU;
              if (idx_q == 4'd8) begin
                idx_d = '0;
                ph_d  = PH_MM;
              end else begin
                idx_d = idx_q + 4'd1;
              end
            end
          end
          PH_MM: begin
            nxt_d[idx_q] = sat(rval);
            if (idx_q == 4'd8) begin
              state_d = ST_COMMIT;
            end else begin
              idx_d = idx_q + 4'd1;
            end
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end

      ST_SQRT: begin
        if (sqrt_done) begin
          idx_d   = '0;
          state_d = ST_DSTART;
          if (ph_q == PH_NSQ) begin
            sden_d = sqrt_root;
            ph_d   = PH_NDIV;
          end else if (sqrt_root == 32'd0) begin
            // parallel or opposite pair: keep the matrix
            state_d = ST_FINISH;
          end else begin
            sden_d = (sqrt_root > 32'(ONE32)) ? 32'(ONE32) : sqrt_root;
            ph_d   = PH_UDIV;
          end
        end
      end

      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          if (ph_q == PH_NDIV) begin
            if (vsel_q) begin
              b_d[idx_q[1:0]] = cur[idx_q[1:0]][31] ? -signed'(div_quo[31:0])
                                                    : signed'(div_quo[31:0]);
            end else begin
              a_d[idx_q[1:0]] = cur[idx_q[1:0]][31] ? -signed'(div_quo[31:0])
                                                    : signed'(div_quo[31:0]);
            end
          end else begin
            u_d[idx_q[1:0]] = n_q[idx_q[1:0]][OP_W-1] ? -signed'(div_quo[OP_W-1:0])
                                                       : signed'(div_quo[OP_W-1:0]);
          end
          if (idx_q == 4'd2) begin
            idx_d = '0;
            if (ph_q == PH_NDIV) begin
              if (!vsel_q) begin
                vsel_d  = 1'b1;
                state_d = ST_ABS;
              end else begin
                ph_d    = PH_CROSS;
                state_d = ST_MAC_A;
              end
            end else begin
              ph_d    = PH_UU;
              state_d = ST_MAC_A;
            end
          end else begin
            idx_d   = idx_q + 4'd1;
            state_d = ST_DSTART;
          end
        end
      end

      ST_COMMIT: begin
        rot_d   = nxt_q;
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d       = rot_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_NSQ;
      idx_q       <= '0;
      term_q      <= '0;
      vsel_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int e = 0; e < 9; e++) begin
        rot_q[e] <= (e == 0 || e == 4 || e == 8) ? ONE32 : 32'sd0;
      end
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      idx_q       <= idx_d;
      term_q      <= term_d;
      vsel_q      <= vsel_d;
      out_valid_q <= out_valid_d;
      rot_q       <= rot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sv_q   <= sv_d;
    ev_q   <= ev_d;
    m_q    <= m_d;
    a_q    <= a_d;
    b_q    <= b_d;
    n_q    <= n_d;
    u_q    <= u_d;
    c_q    <= c_d;
    sden_q <= sden_d;
    t_q    <= t_d;
    opa_q  <= opa_d;
    rt_q   <= rt_d;
    r_q    <= r_d;
    nxt_q  <= nxt_d;
    out_q  <= out_d;
    acc_q  <= acc_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign r00_o = out_q[0];
  assign r01_o = out_q[1];
  assign r02_o = out_q[2];
  assign r10_o = out_q[3];
  assign r11_o = out_q[4];
  assign r12_o = out_q[5];
  assign r20_o = out_q[6];
  assign r21_o = out_q[7];
  assign r22_o = out_q[8];

endmodule

FILE: src/dra_mul.sv
// ----------------------------------------------------------------------------
// dra_mul: bit-serial signed multiplier
// Shift-add over one multiplier bit per cycle; the sign bit is subtracted.
// ----------------------------------------------------------------------------
module dra_mul
  import dra_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [OP_W-1:0]  a_i,
  input  logic signed [OP_W-1:0]  b_i,
  output logic                    done_o,
  output logic signed [ACC_W-1:0] prod_o
);

  localparam logic [5:0] LAST = 6'(OP_W - 1);

  logic                    busy_q, busy_d, done_q, done_d;
  logic [5:0]              cnt_q, cnt_d;
  logic signed [ACC_W-1:0] mcand_q, mcand_d, prod_q, prod_d;
  logic [OP_W-1:0]         mplier_q, mplier_d;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    prod_d   = prod_q;
    mplier_d = mplier_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      mcand_d  = ACC_W'(a_i);
      mplier_d = b_i;
      prod_d   = '0;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        prod_d = (cnt_q == LAST) ? prod_q - mcand_q : prod_q + mcand_q;
      end
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 6'd1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    mcand_q  <= mcand_d;
    prod_q   <= prod_d;
    mplier_q <= mplier_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

FILE: src/dra_div.sv
// ----------------------------------------------------------------------------
// dra_div: restoring unsigned divider
// One quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
module dra_div
  import dra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] num_q, num_d, quo_q, quo_d;
  logic [31:0] den_q, den_d, rem_q, rem_d;
  logic [32:0] trial, diff;
  logic        ge;

  assign trial = {rem_q, num_q[63]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[31:0] : trial[31:0];
      quo_d = {quo_q[62:0], ge};
      num_d = num_q << 1;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: src/dra_sqrt.sv
// ----------------------------------------------------------------------------
// dra_sqrt: digit-by-digit integer square root
// Two radicand bits per cycle, giving the floor of the root.
// ----------------------------------------------------------------------------
module dra_sqrt
  import dra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] rad_q, rad_d;
  logic [34:0] rem_q, rem_d, rem_sh, trial;
  logic [31:0] root_q, root_d;
  logic        ge;

  assign rem_sh = {rem_q[32:0], rad_q[63:62]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = x_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? rem_sh - trial : rem_sh;
      root_d = {root_q[30:0], ge};
      rad_d  = rad_q << 2;
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: dv/drag_rotation_accumulator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drag_rotation_accumulator_checker: rotation predictor and result compare
// Watches both channels of the block. Each input beat advances a private
// copy of the kept matrix; each output beat is compared entry by entry
// with the oldest predicted matrix.
// ----------------------------------------------------------------------------
module drag_rotation_accumulator_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               func_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  input  logic signed [31:0] end_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [8:0][31:0]   mat_i,
  output int                 err_cnt_o,
  output int                 pend_o,
  output int                 drags_o,
  output int                 still_o
);

  localparam int F = 30;
  localparam longint ONE = 64'sd1 <<< F;

  typedef longint trip_t [3];
  typedef logic [8:0][31:0] mat_t;

  mat_t rot_q;
  mat_t want_q[$];

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint sgn(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint rshift(longint v);
    longint unsigned m;
    m = (mag(v) + (64'd1 << (F - 1))) >> F;
    return sgn(m, v < 0);
  endfunction

  function automatic longint clamp1(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit unit_dir(input trip_t v, output trip_t u);
    longint unsigned m[3];
    longint unsigned top, sum, nrm;
    top = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > top) top = m[i];
    end
    if (top == 0) return 0;
    while (top < (64'd1 << 30)) begin
      top = top << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    nrm = isqrt(sum);
    for (int i = 0; i < 3; i++) u[i] = sgn(((m[i] << F) + nrm / 2) / nrm, v[i] < 0);
    return 1;
  endfunction

  // Returns 1 when the drag moved the matrix
  function automatic bit rotate(input trip_t sv, input trip_t ev);
    trip_t a, b, n, u;
    longint r[9];
    longint c, s, omc, acc, uk;
    longint unsigned s2;
    mat_t nxt;
    if (!unit_dir(sv, a) || !unit_dir(ev, b)) return 0;
    n[0] = rshift(a[1] * b[2] - a[2] * b[1]);
    n[1] = rshift(a[2] * b[0] - a[0] * b[2]);
    n[2] = rshift(a[0] * b[1] - a[1] * b[0]);
    c = clamp1(rshift(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]));
    s2 = 0;
    for (int i = 0; i < 3; i++) s2 += n[i] * n[i];
    s = isqrt(s2);
    if (s == 0) return 0;
    if (s > ONE) s = ONE;
    for (int i = 0; i < 3; i++)
      u[i] = sgn((mag(n[i] * ONE) + longint'(s) / 2) / s, n[i] < 0);
    omc = ONE - c;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r[i*3+j] = (i == j ? c : 0) + rshift(omc * rshift(u[i] * u[j]));
    r[1] -= rshift(u[2] * s);
    r[2] += rshift(u[1] * s);
    r[3] += rshift(u[2] * s);
    r[5] -= rshift(u[0] * s);
    r[6] -= rshift(u[1] * s);
    r[7] += rshift(u[0] * s);
    for (int i = 0; i < 9; i++) r[i] = clamp1(r[i]);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) begin
          uk = longint'(signed'(rot_q[k*3+j]));
          acc += r[i*3+k] * uk;
        end
        nxt[i*3+j] = 32'(clamp1(rshift(acc)));
      end
    rot_q = nxt;
    return 1;
  endfunction

  function automatic mat_t ident();
    mat_t m;
    for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 32'(ONE) : 32'd0;
    return m;
  endfunction

  assign pend_o = want_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    mat_t w;
    trip_t sv, ev;
    if (!rst_ni) begin
      rot_q     <= ident();
      want_q.delete();
      err_cnt_o <= 0;
      drags_o   <= 0;
      still_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (want_q.size() == 0) begin
          err_cnt_o <= err_cnt_o + 1;
          if (err_cnt_o < 10) $display("%0t: output beat with nothing expected", $time);
        end else begin
          w = want_q.pop_front();
          if (w !== mat_i) begin
            err_cnt_o <= err_cnt_o + 1;
            if (err_cnt_o < 10)
              for (int i = 0; i < 9; i++)
                if (w[i] !== mat_i[i])
                  $display("%0t: r%0d%0d expected %0d got %0d", $time, i / 3, i % 3,
                           $signed(w[i]), $signed(mat_i[i]));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (func_i) begin
          rot_q = ident();
        end else begin
          sv = '{start_x_i, start_y_i, start_z_i};
          ev = '{end_x_i, end_y_i, end_z_i};
          if (rotate(sv, ev)) drags_o <= drags_o + 1;
          else still_o <= still_o + 1;
        end
        want_q.insert(want_q.size(), rot_q);
      end
    end
  end

endmodule

FILE: dv/tb_drag_rotation_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drag_rotation_accumulator: stimulus and verdict for the drag rotator
// Sends directed and random drag and reset beats with random idling on
// both channels; the checker predicts and compares every output matrix.
// ----------------------------------------------------------------------------
module tb_drag_rotation_accumulator;

  logic clk, rst_n;
  logic in_valid, in_ready, func, out_valid, out_ready;
  logic signed [31:0] sx, sy, sz, ex, ey, ez;
  logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  int   err_cnt, pend, drags, still, resets;
  bit   quiet;

  drag_rotation_accumulator u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .func_i(func),
    .start_x_i(sx), .start_y_i(sy), .start_z_i(sz),
    .end_x_i(ex), .end_y_i(ey), .end_z_i(ez),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .r00_o(r00), .r01_o(r01), .r02_o(r02), .r10_o(r10), .r11_o(r11),
    .r12_o(r12), .r20_o(r20), .r21_o(r21), .r22_o(r22)
  );

  drag_rotation_accumulator_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .func_i(func),
    .start_x_i(sx), .start_y_i(sy), .start_z_i(sz),
    .end_x_i(ex), .end_y_i(ey), .end_z_i(ez),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .mat_i({r22, r21, r20, r12, r11, r10, r02, r01, r00}),
    .err_cnt_o(err_cnt), .pend_o(pend), .drags_o(drags), .still_o(still)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #250_000_000;
    $display("** drag_rotation_accumulator: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 35);
  end

  // Drop valid once the beat is taken and wait for a clock edge before returning
  task automatic send(input logic f, input logic signed [31:0] a0, a1, a2, b0, b1, b2);
    while (!quiet && $urandom_range(0, 99) < 35) begin
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    sx <= a0; sy <= a1; sz <= a2;
    ex <= b0; ey <= b1; ez <= b2;
    if (f) resets++;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random coordinate with a spread of magnitudes
  function automatic logic signed [31:0] coord();
    logic [31:0] v;
    v = $urandom >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  localparam logic signed [31:0] MX = 32'sh7fff_ffff;
  localparam logic signed [31:0] MN = 32'sh8000_0000;
  localparam logic signed [31:0] U1 = 32'sd65536;

  initial begin
    logic signed [31:0] a0, a1, a2;
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0; func = 1'b0; quiet = 1'b0; resets = 0;
    sx = '0; sy = '0; sz = '0; ex = '0; ey = '0; ez = '0;
    out_ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: axes, extremes, zero vectors, parallel and opposite pairs, reset
    send(1'b0, U1, 0, 0, 0, U1, 0);
    send(1'b0, 0, U1, 0, 0, 0, U1);
    send(1'b0, 0, 0, U1, U1, 0, 0);
    send(1'b1, MX, MN, MX, MN, MX, MN);
    send(1'b0, MX, MX, MX, MN, MN, MN);
    send(1'b0, MN, 0, 0, 0, MN, 0);
    send(1'b0, MX, MN, 1, -1, MX, MN);
    send(1'b0, 1, 0, 0, 0, 0, 1);
    send(1'b0, -1, -1, -1, 1, 1, -1);
    send(1'b0, 0, 0, 0, U1, U1, 0);
    send(1'b0, U1, 0, U1, 0, 0, 0);
    send(1'b0, U1, 2 * U1, 3 * U1, U1, 2 * U1, 3 * U1);
    send(1'b0, U1, 2 * U1, 3 * U1, -U1, -2 * U1, -3 * U1);
    send(1'b0, U1, 2 * U1, 3 * U1, 2 * U1, 4 * U1, 6 * U1);
    send(1'b0, U1, 0, 0, U1, 1, 0);
    send(1'b0, MN, MN, MN, MX, MX, MX);
    send(1'b1, 0, 0, 0, 0, 0, 0);
    send(1'b0, 32'sh5555_5555, 32'shaaaa_aaaa, 0, 0, 32'sh5555_5555, 32'shaaaa_aaaa);

    for (int n = 0; n < 1300; n++) begin
      quiet = (n >= 400 && n < 550);
      if (n == 700) begin
        while (pend != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      a0 = coord(); a1 = coord(); a2 = coord();
      if (pick < 8)
        send(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 12)
        send(1'b0, a0, a1, a2, 0, 0, 0);
      else if (pick < 15)
        send(1'b0, 0, 0, 0, a0, a1, a2);
      else if (pick < 19)
        send(1'b0, a0, a1, a2, a0, a1, a2);
      else if (pick < 22)
        send(1'b0, a0, a1, a2, -a0, -a1, -a2);
      else if (pick < 40)
        send(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        send(1'b0, a0, a1, a2, coord(), coord(), coord());
    end
    quiet = 1'b0;
    while (pend != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Coverage: %0d rotating drags, %0d drags left the matrix as is, %0d resets",
             drags, still, resets);
    $display("Mismatch count: %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("** drag_rotation_accumulator: PASSED **");
    end else begin
      $display("** drag_rotation_accumulator: FAILED **");
    end
    $finish;
  end

endmodule
